// ===== sv/ipt_pkg.sv =====
// ----------------------------------------------------------------------------
// ipt_pkg: shared types and constants for the IPv4 prefix trie unit
// Node memory geometry, action and status codes, front-to-back command.
// ----------------------------------------------------------------------------
`default_nettype none
package ipt_pkg;
  localparam int NODE_COUNT = 1024;
  localparam int KEY_BITS   = 32;
  localparam int NW         = $clog2(NODE_COUNT);
  localparam int CW         = $clog2(NODE_COUNT + 1);
  localparam int LW         = $clog2(KEY_BITS + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NONODE   = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [KEY_BITS-1:0] key;
    logic [LW-1:0]       plen;
    logic [7:0]          value;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WT, S_EV, S_POP, S_POPW, S_ALLOC, S_FIN,
    S_PRD, S_PWT, S_PEV, S_DONE
  } bstate_t;

  // prefix length = leading ones of the mask; the highest zero bit sets it
  function automatic logic [LW-1:0] prefix_len(input logic [KEY_BITS-1:0] m);
    logic [LW-1:0] n;
    n = LW'(KEY_BITS);
    for (int i = 0; i < KEY_BITS; i++) begin
      if (!m[i]) n = LW'(KEY_BITS - 1 - i);
    end
    return n;
  endfunction
endpackage
`default_nettype wire

// ===== sv/ipv4_prefix_trie_unit.sv =====
// ----------------------------------------------------------------------------
// ipv4_prefix_trie_unit: binary trie longest-prefix match over IPv4 keys
// Insert, delete and find on a 1024-node trie with a free stack.
// ----------------------------------------------------------------------------
//  channel  | ports                                      | handshake
//  command  | action key prefix_mask entry_value         | start & !busy
//  result   | status found match_value                   | done, one cycle
//
//  Each trie level walked passes issue, wait and evaluate on the single node
//  port; a level that insert has to build adds pop, pop wait, allocate and
//  finish before the walk goes on. Delete walks each pruned ancestor through
//  its own read, wait and evaluate steps.
//  After reset a clearing pass over all 1024 nodes initializes node memory and
//  the free stack; up to two items queue meanwhile, then busy rises. Two
//  commands can queue ahead of the walker. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module ipv4_prefix_trie_unit import ipt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          action,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [KEY_BITS-1:0] prefix_mask,
  input  wire logic [7:0]          entry_value,
  output logic                     done,
  output logic [1:0]               status,
  output logic                     found,
  output logic [7:0]               match_value
);
  logic full, q_valid, q_pop, idle;
  cmd_t q_cmd;

  assign busy = full | rst;

  ipt_front u_front (
    .clk, .rst, .take(start & ~busy), .action, .key, .prefix_mask, .entry_value,
    .full, .q_valid, .q_cmd, .q_pop
  );

  ipt_back u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .idle,
    .res_valid(done), .res_status(status), .res_found(found), .res_value(match_value)
  );

  a_idle: assert property (@(posedge clk) disable iff (rst) idle |-> !done)
    else $error("result while idle");
endmodule
`default_nettype wire

// ===== sv/ipt_ram.sv =====
// ----------------------------------------------------------------------------
// ipt_ram: generic single-port RAM with registered read
// One access per cycle; a read also occurs on every write and returns the old word.
// ----------------------------------------------------------------------------
`default_nettype none
module ipt_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] addr,
  input  wire logic [W-1:0]         wdata,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== sv/ipt_front.sv =====
// ----------------------------------------------------------------------------
// ipt_front: command intake
// Accepts items, reduces the mask to a prefix length, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module ipt_front import ipt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic [1:0]          action,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [KEY_BITS-1:0] prefix_mask,
  input  wire logic [7:0]          entry_value,
  output logic                     full,
  output logic                     q_valid,
  output cmd_t                     q_cmd,
  input  wire logic                q_pop
);
  cmd_t       slot [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full    = cnt == 2'd2;
  assign q_valid = cnt != 2'd0;
  assign q_cmd   = slot[rp];

  always_ff @(posedge clk) begin
    if (take) slot[wp] <= '{action, key, prefix_len(prefix_mask), entry_value};
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (take) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(take) - 2'(q_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) take |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count");
endmodule
`default_nettype wire

// ===== sv/ipt_back.sv =====
// ----------------------------------------------------------------------------
// ipt_back: trie walker
// Runs insert, delete and find over the node memories, one level per pass.
// ----------------------------------------------------------------------------
`default_nettype none
module ipt_back import ipt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire cmd_t       q_cmd,
  output logic            q_pop,
  output logic            idle,
  output logic            res_valid,
  output logic [1:0]      res_status,
  output logic            res_found,
  output logic [7:0]      res_value
);
  bstate_t state, state_next;
  cmd_t    cmd;
  logic [NW-1:0] node, node_next, nx;
  logic [LW-1:0] lvl, lvl_next;
  logic [CW-1:0] fcnt, fcnt_next;
  logic [CW-1:0] sweep;
  logic          swept;
  logic [1:0]    st, st_next;
  logic          fnd, fnd_next;
  logic [7:0]    mv, mv_next;
  // child just released during prune
  logic [NW-1:0] child;

  // node memories
  logic          n_we;
  logic [NW-1:0] n_addr, l_wd, r_wd, p_wd, l_rd, r_rd, p_rd;
  logic [7:0]    v_wd, v_rd;
  logic          vv_wd, vv_rd;
  logic          f_we;
  logic [NW-1:0] f_addr, f_wd, f_rd;

  // a node is written as a whole record; fields not changed are written back
  ipt_ram #(.W(NW), .D(NODE_COUNT)) u_l (.clk, .we(n_we), .addr(n_addr), .wdata(l_wd), .rdata(l_rd));
  ipt_ram #(.W(NW), .D(NODE_COUNT)) u_r (.clk, .we(n_we), .addr(n_addr), .wdata(r_wd), .rdata(r_rd));
  ipt_ram #(.W(NW), .D(NODE_COUNT)) u_p (.clk, .we(n_we), .addr(n_addr), .wdata(p_wd), .rdata(p_rd));
  ipt_ram #(.W(8), .D(NODE_COUNT))  u_v (.clk, .we(n_we), .addr(n_addr), .wdata(v_wd), .rdata(v_rd));
  ipt_ram #(.W(1), .D(NODE_COUNT))  u_vv(.clk, .we(n_we), .addr(n_addr), .wdata(vv_wd), .rdata(vv_rd));
  ipt_ram #(.W(NW), .D(NODE_COUNT)) u_f (.clk, .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

  logic [KEY_BITS-1:0] kshift;
  logic kb, more, leaf;
  assign kshift = cmd.key << lvl;
  assign kb     = kshift[KEY_BITS-1];
  assign more   = lvl < cmd.plen;
  assign nx     = kb ? r_rd : l_rd;
  assign leaf   = (l_rd == '0) && (r_rd == '0);
  assign idle   = state == S_IDLE && !q_valid && swept;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && swept) cmd <= q_cmd;
    if (rst) begin
      state <= S_IDLE; fcnt <= CW'(NODE_COUNT - 1); sweep <= '0; swept <= 1'b0;
    end else begin
      state <= state_next; fcnt <= fcnt_next;
      if (!swept) begin
        sweep <= sweep + 1'b1;
        if (sweep == CW'(NODE_COUNT - 1)) swept <= 1'b1;
      end
    end
    node <= node_next; lvl <= lvl_next; st <= st_next; fnd <= fnd_next; mv <= mv_next;
  end

  always_comb begin
    state_next = state; node_next = node; lvl_next = lvl; fcnt_next = fcnt;
    st_next = st; fnd_next = fnd; mv_next = mv;
    q_pop = 1'b0; res_valid = 1'b0;
    n_we = 1'b0; n_addr = node; l_wd = l_rd; r_wd = r_rd; p_wd = p_rd;
    v_wd = v_rd; vv_wd = vv_rd;
    f_we = 1'b0; f_addr = fcnt[NW-1:0] - 1'b1; f_wd = node;
    if (!swept) begin
      // clear pass: every node empty, free stack gets nodes 1..N-1
      n_we = 1'b1; n_addr = sweep[NW-1:0];
      l_wd = '0; r_wd = '0; p_wd = '0; v_wd = '0; vv_wd = 1'b0;
      f_we = 1'b1; f_addr = sweep[NW-1:0]; f_wd = sweep[NW-1:0] + 1'b1;
    end else begin
      case (state)
        S_IDLE: if (q_valid) begin
          q_pop = 1'b1; node_next = '0; lvl_next = '0;
          st_next = ST_NOTFOUND; fnd_next = 1'b0; mv_next = '0;
          state_next = S_RD;
        end
        S_RD: state_next = S_WT;
        S_WT: state_next = S_EV;
        S_EV: begin
          case (cmd.action)
            ACT_FIND: begin
              if (vv_rd) begin fnd_next = 1'b1; mv_next = v_rd; st_next = ST_OK; end
              if (nx == '0 || lvl == LW'(KEY_BITS)) state_next = S_DONE;
              else begin node_next = nx; lvl_next = lvl + 1'b1; state_next = S_RD; end
            end
            ACT_INSERT: begin
              if (!more) begin
                if (vv_rd) st_next = ST_PRESENT;
                else begin
                  st_next = ST_OK; n_we = 1'b1; v_wd = cmd.value; vv_wd = 1'b1;
                end
                state_next = S_DONE;
              end else if (nx != '0) begin
                node_next = nx; lvl_next = lvl + 1'b1; state_next = S_RD;
              end else if (fcnt == '0) begin
                st_next = ST_NONODE; state_next = S_DONE;
              end else state_next = S_POP;
            end
            ACT_DELETE: begin
              if (more) begin
                if (nx == '0) state_next = S_DONE;
                else begin node_next = nx; lvl_next = lvl + 1'b1; state_next = S_RD; end
              end else if (node == '0) state_next = S_DONE;
              else if (!leaf) begin
                if (vv_rd) begin st_next = ST_OK; n_we = 1'b1; vv_wd = 1'b0; end
                state_next = S_DONE;
              end else begin
                // release leaf: clear it, push it, then unlink from parent
                st_next = ST_OK;
                n_we = 1'b1; l_wd = '0; r_wd = '0; vv_wd = 1'b0;
                if (fcnt < CW'(NODE_COUNT)) begin
                  f_we = 1'b1; f_addr = fcnt[NW-1:0]; fcnt_next = fcnt + 1'b1;
                end
                mv_next = '0;
                lvl_next = lvl; // keep
                node_next = p_rd; fnd_next = 1'b0;
                state_next = S_PRD;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
        S_POP: state_next = S_POPW; // free stack read at top
        S_POPW: begin
          fcnt_next = fcnt - 1'b1;
          // link new node into the current one
          n_we = 1'b1;
          if (kb) r_wd = f_rd; else l_wd = f_rd;
          state_next = S_ALLOC;
        end
        S_ALLOC: begin
          n_we = 1'b1; n_addr = f_rd;
          l_wd = '0; r_wd = '0; p_wd = node; vv_wd = 1'b0;
          node_next = f_rd; lvl_next = lvl + 1'b1;
          state_next = S_FIN;
        end
        S_FIN: state_next = S_RD;
        S_PRD: state_next = S_PWT;
        S_PWT: state_next = S_PEV;
        S_PEV: begin
          // child released was at key bit lvl-1 of parent
          n_we = 1'b1;
          if (r_rd == child) r_wd = '0; else l_wd = '0;
          lvl_next = lvl - 1'b1;
          if ((r_rd != child && r_rd != '0) || (r_rd == child && l_rd != '0)
              || vv_rd || node == '0) state_next = S_DONE;
          else begin
            l_wd = '0; r_wd = '0; vv_wd = 1'b0;
            if (fcnt < CW'(NODE_COUNT)) begin
              f_we = 1'b1; f_addr = fcnt[NW-1:0]; fcnt_next = fcnt + 1'b1;
            end
            node_next = p_rd;
            state_next = S_PRD;
          end
        end
        S_DONE: begin
          res_valid = 1'b1; state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EV || state == S_PEV) child <= node;
  end

  assign res_status = st;
  assign res_found  = fnd;
  assign res_value  = mv;

  a_fcnt: assert property (@(posedge clk) disable iff (rst) fcnt <= CW'(NODE_COUNT))
    else $error("free count out of range");
  a_done: assert property (@(posedge clk) disable iff (rst) res_valid |=> state == S_IDLE)
    else $error("result not followed by idle");
  a_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_found |-> res_status == ST_OK) else $error("found status");
endmodule
`default_nettype wire

// ===== tb/ipv4_prefix_trie_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_prefix_trie_checker: result predictor and scoreboard
// Mirrors the trie in its own node arrays, predicts each accepted item and
// compares every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module ipv4_prefix_trie_checker import ipt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [1:0]          action,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic [KEY_BITS-1:0] prefix_mask,
  input  wire logic [7:0]          entry_value,
  input  wire logic                done,
  input  wire logic [1:0]          status,
  input  wire logic                found,
  input  wire logic [7:0]          match_value,
  output int                       errors,
  output int                       pending,
  output int                       results_seen
);
  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [7:0] value;
  } answer_t;

  logic [NW-1:0] lchild [NODE_COUNT];
  logic [NW-1:0] rchild [NODE_COUNT];
  logic [NW-1:0] parent [NODE_COUNT];
  logic [7:0]    val    [NODE_COUNT];
  logic          valid  [NODE_COUNT];
  logic [NW-1:0] free_stk [NODE_COUNT];
  int            free_top;
  answer_t       answers [$];

  assign pending = answers.size();

  task automatic trie_clear();
    for (int i = 0; i < NODE_COUNT; i++) begin
      lchild[i] = '0; rchild[i] = '0; parent[i] = '0; val[i] = '0; valid[i] = 1'b0;
      free_stk[i] = NW'(i + 1);
    end
    free_top = NODE_COUNT - 1;
    answers.delete();
  endtask

  function automatic logic [NW-1:0] next_node(int n, logic [KEY_BITS-1:0] k, int b);
    return k[b] ? rchild[n] : lchild[n];
  endfunction

  function automatic answer_t trie_insert(logic [KEY_BITS-1:0] k, int plen,
                                          logic [7:0] v);
    answer_t a;
    int node, b, nx;
    a = '0;
    node = 0;
    b = KEY_BITS - 1;
    while (KEY_BITS - 1 - b < plen && next_node(node, k, b) != 0) begin
      node = int'(next_node(node, k, b));
      b--;
    end
    while (KEY_BITS - 1 - b < plen) begin
      if (free_top == 0) begin
        a.status = ST_NONODE;
        return a;
      end
      free_top--;
      nx = int'(free_stk[free_top]);
      lchild[nx] = '0; rchild[nx] = '0; valid[nx] = 1'b0;
      parent[nx] = NW'(node);
      if (k[b]) rchild[node] = NW'(nx);
      else lchild[node] = NW'(nx);
      node = nx;
      b--;
    end
    if (valid[node]) begin
      a.status = ST_PRESENT;
      return a;
    end
    val[node] = v;
    valid[node] = 1'b1;
    a.status = ST_OK;
    return a;
  endfunction

  function automatic answer_t trie_delete(logic [KEY_BITS-1:0] k, int plen);
    answer_t a;
    int node, up;
    a = '0;
    a.status = ST_NOTFOUND;
    node = 0;
    for (int d = 0; d < plen; d++) begin
      node = int'(next_node(node, k, KEY_BITS - 1 - d));
      if (node == 0) return a;
    end
    if (node == 0) return a;
    if (lchild[node] != 0 || rchild[node] != 0) begin
      if (!valid[node]) return a;
      valid[node] = 1'b0;
      a.status = ST_OK;
      return a;
    end
    // leaf: unlink and prune empty ancestors back to the free stack
    for (int g = 0; g < NODE_COUNT; g++) begin
      up = int'(parent[node]);
      if (rchild[up] == node) rchild[up] = '0;
      else lchild[up] = '0;
      valid[node] = 1'b0; lchild[node] = '0; rchild[node] = '0;
      if (free_top < NODE_COUNT) begin
        free_stk[free_top] = NW'(node);
        free_top++;
      end
      node = up;
      if (lchild[node] != 0 || rchild[node] != 0 || valid[node] || node == 0) break;
    end
    a.status = ST_OK;
    return a;
  endfunction

  function automatic answer_t trie_lookup(logic [KEY_BITS-1:0] k);
    answer_t a;
    int node, b;
    a = '0;
    node = 0;
    b = KEY_BITS - 1;
    for (int g = 0; g <= KEY_BITS; g++) begin
      if (valid[node]) begin
        a.found = 1'b1;
        a.value = val[node];
      end
      if (b < 0) break;
      node = int'(next_node(node, k, b));
      b--;
      if (node == 0) break;
    end
    a.status = a.found ? ST_OK : ST_NOTFOUND;
    return a;
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    trie_clear();
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      trie_clear();
    end else begin
      if (start && !busy) begin
        case (action)
          ACT_INSERT: e = trie_insert(key, int'(prefix_len(prefix_mask)), entry_value);
          ACT_DELETE: e = trie_delete(key, int'(prefix_len(prefix_mask)));
          ACT_FIND:   e = trie_lookup(key);
          default:    e = '{status: ST_NOTFOUND, found: 1'b0, value: 8'h00};
        endcase
        answers.push_back(e);
      end
      if (done) begin
        results_seen++;
        if (answers.size() == 0) begin
          report("unexpected result", 8'(status), 8'h00);
        end else begin
          e = answers.pop_front();
          if (status !== e.status) report("status", 8'(status), 8'(e.status));
          if (found !== e.found) report("found", 8'(found), 8'(e.found));
          if (match_value !== e.value) report("match_value", match_value, e.value);
        end
      end
    end
  end
endmodule

// ===== tb/tb_ipv4_prefix_trie_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_prefix_trie_unit: stimulus and verdict for the prefix trie unit
// Directed corner items, then bursts of random insert/delete/find/unused traffic
// over a small key pool so that hits, prunes and exhaustion all occur.
// ----------------------------------------------------------------------------
module tb_ipv4_prefix_trie_unit;
  import ipt_pkg::*;

  logic                clk;
  logic                rst;
  logic                start;
  logic [1:0]          action;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] prefix_mask;
  logic [7:0]          entry_value;
  wire                 busy;
  wire                 done;
  wire [1:0]           status;
  wire                 found;
  wire [7:0]           match_value;
  int                  errors;
  int                  pending;
  int                  results_seen;
  int                  items_sent;

  ipv4_prefix_trie_unit uut (
    .clk, .rst, .start, .busy, .action, .key, .prefix_mask, .entry_value,
    .done, .status, .found, .match_value
  );

  ipv4_prefix_trie_checker chk (
    .clk, .rst, .start, .busy, .action, .key, .prefix_mask, .entry_value,
    .done, .status, .found, .match_value, .errors, .pending, .results_seen
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // leading-ones mask of the given length
  function automatic logic [KEY_BITS-1:0] mask_of(int n);
    return (n == 0) ? '0 : ~((KEY_BITS'(1) << (KEY_BITS - n)) - 1);
  endfunction

  // drive one item and hold it until the unit takes it
  task automatic send(logic [1:0] a, logic [KEY_BITS-1:0] k,
                      logic [KEY_BITS-1:0] m, logic [7:0] v);
    start <= 1'b1;
    action <= a;
    key <= k;
    prefix_mask <= m;
    entry_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    action <= 2'($urandom);
    key <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // random item over a narrow key space; gaps and tails of masks vary
  task automatic random_item();
    logic [1:0]          a;
    logic [KEY_BITS-1:0] k, m;
    int                  n, r;
    r = $urandom_range(0, 99);
    a = (r < 40) ? ACT_INSERT : (r < 65) ? ACT_DELETE : (r < 97) ? ACT_FIND : ACT_UNUSED;
    k = {4'($urandom_range(0, 15)), 28'h0} | ($urandom_range(0, 3) == 0 ? $urandom : 32'h0);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 6);
    m = mask_of(n);
    if ($urandom_range(0, 7) == 0) m = m | (32'($urandom) & ~mask_of(n + 1 > 32 ? 32 : n + 1));
    send(a, k, m, 8'($urandom));
  endtask

  initial begin
    int burst;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_FIND;
    key = '0;
    prefix_mask = '0;
    entry_value = '0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send(ACT_FIND,   32'h0, 32'h0, 8'h00);          // empty trie
    send(ACT_DELETE, 32'h0, 32'h0, 8'h00);          // root delete refused
    send(ACT_INSERT, 32'h0, 32'h0, 8'hff);          // default route at root
    send(ACT_INSERT, 32'h0, 32'h0, 8'h11);          // already present
    send(ACT_INSERT, 32'hc0a80000, mask_of(16), 8'h5a);
    send(ACT_INSERT, 32'hc0a80100, mask_of(24), 8'ha5);
    send(ACT_FIND,   32'hc0a80101, 32'h0, 8'h00);
    send(ACT_FIND,   32'hc0a8ff01, 32'h0, 8'h00);
    send(ACT_INSERT, 32'hffffffff, 32'hffffffff, 8'h01);
    send(ACT_INSERT, 32'h00000000, 32'hffffffff, 8'h80);
    send(ACT_FIND,   32'hffffffff, 32'hffffffff, 8'h00);
    send(ACT_FIND,   32'h00000000, 32'h0, 8'h00);
    send(ACT_INSERT, 32'h12345678, 32'hff00ff00, 8'h33); // mask with gaps
    send(ACT_DELETE, 32'hc0a80000, mask_of(8), 8'h00);   // inner node, no value
    send(ACT_DELETE, 32'h0a000000, mask_of(8), 8'h00);   // missing path
    send(ACT_DELETE, 32'hc0a80000, mask_of(16), 8'h00);  // inner node with value
    send(ACT_DELETE, 32'hc0a80100, mask_of(24), 8'h00);  // leaf, prune
    send(ACT_DELETE, 32'h12000000, mask_of(8), 8'h00);   // leaf with value, prune
    send(ACT_UNUSED, 32'hffffffff, 32'hffffffff, 8'hff);
    send(ACT_DELETE, 32'hffffffff, 32'hffffffff, 8'h00);
    send(ACT_FIND,   32'hffffffff, 32'h0, 8'h00);

    // exhaust the node pool with full-length prefixes, then delete along key zero
    for (int i = 0; i < 36; i++) send(ACT_INSERT, $urandom, 32'hffffffff, 8'(i));
    send(ACT_FIND, 32'h0, 32'h0, 8'h00);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 40; i++) send(ACT_DELETE, 32'h0, mask_of(i % 33), 8'h00);

    // random bursts
    while (items_sent < 640) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst; i++) random_item();
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 60));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d items, checked %0d results (insert, delete, find, pool exhaustion)",
             items_sent, results_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
